@@ hw/rtl/differential_odometry_tracker_top_defines.svh @@
// assertion macros for the odometry tracker
// expects clock and reset to be visible where a macro is used
`ifndef DIFFERENTIAL_ODOMETRY_TRACKER_TOP_DEFINES_SVH
`define DIFFERENTIAL_ODOMETRY_TRACKER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DOT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DOT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/dot_pkg.sv @@
// shared types, constants and the arctangent lookup for the odometry tracker
// no dependencies
package dot_pkg;

   localparam int FULL_TURN        = 36000;
   localparam int HALF_TURN        = 18000;
   localparam int QUARTER_TURN     = 9000;
   localparam int THREE_QTR_TURN   = 27000;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ATAN_IDX_W       = $clog2(ATAN_ENTRIES);
   localparam int CORDIC_W         = 32;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic [31:0] DPC_RESET = 32'd2617400;

   localparam int POS_W      = 48;
   localparam int ENC_W      = 32;
   localparam int HEAD_W     = 16;
   localparam int SUM_W      = 34;
   localparam int CHUNK_W    = 21;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = CHUNK_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + CHUNK_W;
   localparam int DIST_W     = 42;
   localparam int DIST_SHIFT = 23;
   localparam int DELTA_W    = 43;
   localparam int PROJ_SHIFT = 30;

   localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 48'sh8000_0000_0000;

   typedef enum logic [0:0] {
      ACT_UPDATE = 1'b0,
      ACT_RESET  = 1'b1
   } action_type;

   typedef struct packed {
      action_type               action;
      logic signed [ENC_W-1:0]  left_position;
      logic signed [ENC_W-1:0]  right_position;
      logic [HEAD_W-1:0]        sensor_heading;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  x_position;
      logic signed [POS_W-1:0]  y_position;
      logic [HEAD_W-1:0]        pose_heading;
   } rsp_type;

   // one partial product for the multiply-accumulate unit
   typedef struct packed {
      logic                     valid;
      logic                     clear;
      logic                     high;
      logic [CHUNK_W-1:0]       a;
      logic [MUL_B_W-1:0]       b;
   } mac_op_type;

   typedef struct packed {
      logic                       done;
      logic signed [CORDIC_W-1:0] cos_q30;
      logic signed [CORDIC_W-1:0] sin_q30;
   } cordic_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_WAIT,
      ST_PROJ_X,
      ST_PROJ_Y,
      ST_FINISH
   } state_type;

   // atan(2^-i) in centidegrees scaled by 2^16
   function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CORDIC_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'sd294912000;
         5'd1:    val = 32'sd174096719;
         5'd2:    val = 32'sd91987925;
         5'd3:    val = 32'sd46694507;
         5'd4:    val = 32'sd23437865;
         5'd5:    val = 32'sd11730358;
         5'd6:    val = 32'sd5866610;
         5'd7:    val = 32'sd2933484;
         5'd8:    val = 32'sd1466764;
         5'd9:    val = 32'sd733385;
         5'd10:   val = 32'sd366693;
         5'd11:   val = 32'sd183346;
         5'd12:   val = 32'sd91673;
         5'd13:   val = 32'sd45837;
         5'd14:   val = 32'sd22918;
         5'd15:   val = 32'sd11459;
         5'd16:   val = 32'sd5730;
         5'd17:   val = 32'sd2865;
         5'd18:   val = 32'sd1432;
         5'd19:   val = 32'sd716;
         5'd20:   val = 32'sd358;
         5'd21:   val = 32'sd179;
         5'd22:   val = 32'sd90;
         5'd23:   val = 32'sd45;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/dot_mac.sv @@
// shared multiply-accumulate unit: 21x32 partial product, then shifted add
// depends on dot_pkg
module dot_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  dot_pkg::mac_op_type         op,
   output logic [dot_pkg::ACC_W-1:0]   acc
);
   import dot_pkg::*;

   logic               pvalid_ff, pvalid_in;
   logic               clear_ff;
   logic               high_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   addend;

   always_comb begin
      prod_in   = PROD_W'(op.a) * PROD_W'(op.b);
      pvalid_in = op.valid;
      // upper chunk weighs 2^CHUNK_W
      addend    = high_ff ? {prod_ff, {CHUNK_W{1'b0}}} : ACC_W'(prod_ff);
      acc_in    = acc_ff;
      if (pvalid_ff) begin
         acc_in = (clear_ff ? '0 : acc_ff) + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
      end
      prod_ff  <= prod_in;
      clear_ff <= op.clear;
      high_ff  <= op.high;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ hw/rtl/dot_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on dot_pkg
module dot_cordic #(
   parameter int CORDIC_STEPS = dot_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dot_pkg::HEAD_W-1:0]   angle,
   output dot_pkg::cordic_res_type      res
);
   import dot_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        flip_ff, flip_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [CORDIC_W-1:0]  x_ff, x_in;
   logic signed [CORDIC_W-1:0]  y_ff, y_in;
   logic signed [CORDIC_W-1:0]  z_ff, z_in;

   logic signed [HEAD_W:0]      angle_s;
   logic signed [HEAD_W:0]      theta_wide;
   logic                        flip_now;
   logic signed [CORDIC_W-1:0]  xs, ys, atan_val;

   always_comb begin
      // fold into [-90, 90] degrees, negate result for the half turn
      angle_s  = $signed({1'b0, angle});
      flip_now = 1'b0;
      if (angle > HEAD_W'(QUARTER_TURN) && angle < HEAD_W'(THREE_QTR_TURN)) begin
         theta_wide = angle_s - (HEAD_W+1)'(HALF_TURN);
         flip_now   = 1'b1;
      end else if (angle >= HEAD_W'(THREE_QTR_TURN)) begin
         theta_wide = angle_s - (HEAD_W+1)'(FULL_TURN);
      end else begin
         theta_wide = angle_s;
      end

      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      atan_val = atan_lut(ATAN_IDX_W'(step_ff));

      busy_in = busy_ff;
      done_in = done_ff;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;

      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = {theta_wide[HEAD_W-1:0], {(CORDIC_W-HEAD_W){1'b0}}};
         flip_in = flip_now;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign res.done    = done_ff;
   assign res.cos_q30 = flip_ff ? -x_ff : x_ff;
   assign res.sin_q30 = flip_ff ? -y_ff : y_ff;

endmodule

@@ hw/rtl/differential_odometry_tracker_top.sv @@
// top level of the differential-drive odometry tracker
// depends on dot_pkg, dot_mac, dot_cordic and the assertion macro header
//
// usage
//   req channel (valid/ready) carries one request: action, left and right
//   encoder positions and the sensor heading. rsp channel (valid/ready)
//   returns the pose after that request. csr channel writes the distance
//   per encoder centidegree; the write is always taken, and should only be
//   issued while no request is in flight.
// sequence
//   an update request is taken in idle and starts the cordic, while the
//   shared multiplier forms the travel distance; once the cordic is done the
//   same multiplier projects the distance onto x and y in two passes, then
//   the finish state loads the pose into the rsp register. a reset request
//   goes from idle straight to the finish state. the next request is taken
//   only when the sequencer is back in idle, so requests do not overlap.
// reset
//   synchronous active-high reset clears pose, encoder references and the
//   heading, and reloads distance_per_count with its default value
// stall
//   the finished pose sits in the rsp register; if it is still there when
//   a new pose is done, the sequencer holds in finish and req_ready stays low
`include "differential_odometry_tracker_top_defines.svh"

module differential_odometry_tracker_top #(
   parameter int CORDIC_STEPS = dot_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dot_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dot_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import dot_pkg::*;

   // sequencer
   state_type                   state_ff, state_in;
   logic [1:0]                  cnt_ff, cnt_in;

   // configuration and architectural state
   logic [MUL_B_W-1:0]          dpc_ff, dpc_in;
   logic signed [ENC_W-1:0]     last_left_ff, last_left_in;
   logic signed [ENC_W-1:0]     last_right_ff, last_right_in;
   logic signed [POS_W-1:0]     pose_x_ff, pose_x_in;
   logic signed [POS_W-1:0]     pose_y_ff, pose_y_in;
   logic [HEAD_W-1:0]           pose_angle_ff, pose_angle_in;

   // working registers of the request in flight
   logic signed [ENC_W-1:0]     left_ff, left_in;
   logic signed [ENC_W-1:0]     right_ff, right_in;
   logic [HEAD_W-1:0]           heading_ff, heading_in;
   logic [SUM_W-1:0]            sum_mag_ff, sum_mag_in;
   logic                        sum_neg_ff, sum_neg_in;
   logic [DIST_W-1:0]           dist_mag_ff, dist_mag_in;
   logic                        dist_neg_ff, dist_neg_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_payload_ff, rsp_payload_in;

   // shared units
   mac_op_type                  mac_op;
   logic [ACC_W-1:0]            mac_acc;
   logic                        cordic_start;
   cordic_res_type              cordic_res;

   logic                        req_take;
   logic signed [SUM_W-1:0]     sum_now;
   logic [MUL_B_W-1:0]          cos_mag, sin_mag;
   logic [DELTA_W-1:0]          delta_mag;
   logic                        rsp_load;

   // saturating add of a signed magnitude onto a pose coordinate
   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0] base,
      input logic [DELTA_W-1:0]      mag,
      input logic                    neg
   );
      logic signed [POS_W:0] step;
      logic signed [POS_W:0] total;
      logic signed [POS_W-1:0] res;
      step  = $signed({{(POS_W+1-DELTA_W){1'b0}}, mag});
      step  = neg ? -step : step;
      total = $signed({base[POS_W-1], base}) + step;
      unique case (total[POS_W:POS_W-1])
         2'b01:   res = POS_MAX;
         2'b10:   res = POS_MIN;
         default: res = total[POS_W-1:0];
      endcase
      return res;
   endfunction

   dot_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (mac_acc)
   );

   dot_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (pose_angle_ff),
      .res   (cordic_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // exact sum of both encoder deltas
   assign sum_now = ($signed({{(SUM_W-ENC_W){req_payload.left_position[ENC_W-1]}},
                               req_payload.left_position})
                   - $signed({{(SUM_W-ENC_W){last_left_ff[ENC_W-1]}}, last_left_ff}))
                  + ($signed({{(SUM_W-ENC_W){req_payload.right_position[ENC_W-1]}},
                               req_payload.right_position})
                   - $signed({{(SUM_W-ENC_W){last_right_ff[ENC_W-1]}}, last_right_ff}));

   assign cos_mag   = cordic_res.cos_q30[CORDIC_W-1] ? MUL_B_W'(-cordic_res.cos_q30)
                                                     : MUL_B_W'(cordic_res.cos_q30);
   assign sin_mag   = cordic_res.sin_q30[CORDIC_W-1] ? MUL_B_W'(-cordic_res.sin_q30)
                                                     : MUL_B_W'(cordic_res.sin_q30);
   assign delta_mag = mac_acc[PROJ_SHIFT +: DELTA_W];

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      dpc_in         = dpc_ff;
      last_left_in   = last_left_ff;
      last_right_in  = last_right_ff;
      pose_x_in      = pose_x_ff;
      pose_y_in      = pose_y_ff;
      pose_angle_in  = pose_angle_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      heading_in     = heading_ff;
      sum_mag_in     = sum_mag_ff;
      sum_neg_in     = sum_neg_ff;
      dist_mag_in    = dist_mag_ff;
      dist_neg_in    = dist_neg_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_load       = 1'b0;
      cordic_start   = 1'b0;
      mac_op         = '0;

      if (csr_valid && csr_ready) begin
         dpc_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_payload.action == ACT_RESET) begin
                  // zero pose and latch encoder references
                  pose_x_in     = '0;
                  pose_y_in     = '0;
                  pose_angle_in = '0;
                  last_left_in  = req_payload.left_position;
                  last_right_in = req_payload.right_position;
                  state_in      = ST_FINISH;
               end else begin
                  left_in      = req_payload.left_position;
                  right_in     = req_payload.right_position;
                  heading_in   = (req_payload.sensor_heading >= HEAD_W'(FULL_TURN))
                               ? req_payload.sensor_heading - HEAD_W'(FULL_TURN)
                               : req_payload.sensor_heading;
                  sum_neg_in   = sum_now[SUM_W-1];
                  sum_mag_in   = sum_now[SUM_W-1] ? SUM_W'(-sum_now) : SUM_W'(sum_now);
                  cordic_start = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            // |sum| * distance_per_count, two chunks, then drop 23 bits
            mac_op.b = dpc_ff;
            mac_op.a = (cnt_ff == 2'd0) ? sum_mag_ff[CHUNK_W-1:0]
                                        : CHUNK_W'(sum_mag_ff[SUM_W-1:CHUNK_W]);
            mac_op.valid = (cnt_ff == 2'd0) || (cnt_ff == 2'd1);
            mac_op.clear = (cnt_ff == 2'd0);
            mac_op.high  = (cnt_ff == 2'd1);
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               dist_mag_in = mac_acc[DIST_SHIFT +: DIST_W];
               dist_neg_in = sum_neg_ff;
               state_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            cnt_in = '0;
            if (cordic_res.done) begin
               state_in = ST_PROJ_X;
            end
         end
         ST_PROJ_X, ST_PROJ_Y: begin
            // |dist| * |cos| or |sin|, keep bits above Q30
            mac_op.b = (state_ff == ST_PROJ_X) ? cos_mag : sin_mag;
            mac_op.a = (cnt_ff == 2'd0) ? dist_mag_ff[CHUNK_W-1:0]
                                        : dist_mag_ff[DIST_W-1:CHUNK_W];
            mac_op.valid = (cnt_ff == 2'd0) || (cnt_ff == 2'd1);
            mac_op.clear = (cnt_ff == 2'd0);
            mac_op.high  = (cnt_ff == 2'd1);
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               if (state_ff == ST_PROJ_X) begin
                  pose_x_in = sat_add(pose_x_ff, delta_mag,
                                      dist_neg_ff ^ cordic_res.cos_q30[CORDIC_W-1]);
                  state_in  = ST_PROJ_Y;
               end else begin
                  pose_y_in     = sat_add(pose_y_ff, delta_mag,
                                          dist_neg_ff ^ cordic_res.sin_q30[CORDIC_W-1]);
                  pose_angle_in = heading_ff;
                  last_left_in  = left_ff;
                  last_right_in = right_ff;
                  state_in      = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // wait for a free result register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load                    = 1'b1;
               rsp_payload_in.x_position   = pose_x_ff;
               rsp_payload_in.y_position   = pose_y_ff;
               rsp_payload_in.pose_heading = pose_angle_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         dpc_ff        <= DPC_RESET;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_angle_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         dpc_ff        <= dpc_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         pose_angle_ff <= pose_angle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      left_ff        <= left_in;
      right_ff       <= right_in;
      heading_ff     <= heading_in;
      sum_mag_ff     <= sum_mag_in;
      sum_neg_ff     <= sum_neg_in;
      dist_mag_ff    <= dist_mag_in;
      dist_neg_ff    <= dist_neg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `DOT_ASSERT_NEXT(a_update_starts, req_take && req_payload.action == ACT_UPDATE, state_ff == ST_DIST, "update request did not start the distance pass")
   `DOT_ASSERT_NEXT(a_reset_clears, req_take && req_payload.action == ACT_RESET, pose_x_ff == '0 && pose_y_ff == '0 && pose_angle_ff == '0, "reset request left a nonzero pose")
   `DOT_ASSERT_SAME(a_proj_after_cordic, state_ff == ST_PROJ_X || state_ff == ST_PROJ_Y, cordic_res.done, "projection ran before the cordic finished")
   `DOT_ASSERT_SAME(a_heading_range, 1'b1, pose_angle_ff < HEAD_W'(FULL_TURN), "stored heading out of range")

endmodule
